// ===== rtl/cdo_pkg.sv =====
// Calendar date offset: shared constants, command and status types,
// and the month tables. No dependencies.
package cdo_pkg;

	localparam int COUNT_W    = 16;     // width of the day_count field
	localparam int COUNT_BITS = 16;     // low bits of day_count that are used
	localparam int YEAR_W     = 14;
	localparam int MAX_YEAR   = 9999;

	// y / 100 as (y * RECIP100) >> SHIFT100, exact for 14-bit y
	localparam int RECIP100 = 5243;
	localparam int SHIFT100 = 19;
	// s / 7 as (s * RECIP7) >> SHIFT7, exact for 14-bit s
	localparam int RECIP7   = 37450;
	localparam int SHIFT7   = 18;

	typedef logic [3:0] cmd_code_t;

	localparam cmd_code_t CMD_NONE  = 4'd0;
	localparam cmd_code_t CMD_LOAD  = 4'd1;
	localparam cmd_code_t CMD_INITQ = 4'd2;
	localparam cmd_code_t CMD_INITC = 4'd3;
	localparam cmd_code_t CMD_STEP  = 4'd4;
	localparam cmd_code_t CMD_ERR   = 4'd5;
	localparam cmd_code_t CMD_WSUM  = 4'd6;
	localparam cmd_code_t CMD_WMUL  = 4'd7;
	localparam cmd_code_t CMD_WFIN  = 4'd8;
	localparam cmd_code_t CMD_OUT   = 4'd9;

	typedef struct packed {
		cmd_code_t op;
	} cmd_t;

	typedef struct packed {
		logic date_ok;
		logic cnt_zero;
		logic year_bad;
	} sts_t;

	function automatic logic [4:0] days_in(input logic [3:0] m, input logic leap);
		logic [4:0] n;
		case (m)
			4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: n = 5'd31;
			4'd4, 4'd6, 4'd9, 4'd11:                    n = 5'd30;
			4'd2:                                       n = leap ? 5'd29 : 5'd28;
			default:                                    n = 5'd0;
		endcase
		return n;
	endfunction

	// Sakamoto month offsets
	function automatic logic [2:0] wd_offset(input logic [3:0] m);
		logic [2:0] o;
		case (m)
			4'd1:    o = 3'd0;
			4'd2:    o = 3'd3;
			4'd3:    o = 3'd2;
			4'd4:    o = 3'd5;
			4'd5:    o = 3'd0;
			4'd6:    o = 3'd3;
			4'd7:    o = 3'd5;
			4'd8:    o = 3'd1;
			4'd9:    o = 3'd4;
			4'd10:   o = 3'd6;
			4'd11:   o = 3'd2;
			4'd12:   o = 3'd4;
			default: o = 3'd0;
		endcase
		return o;
	endfunction

endpackage

// ===== rtl/cdo_in_if.sv =====
// Request channel of the calendar date offset block.
// Depends on cdo_pkg for field widths.
interface cdo_in_if import cdo_pkg::*; ();
	logic                valid;
	logic                ready;
	logic                operation;
	logic [4:0]          start_day;
	logic [3:0]          start_month;
	logic [YEAR_W-1:0]   start_year;
	logic [COUNT_W-1:0]  day_count;

	modport source (output valid, operation, start_day, start_month, start_year, day_count,
		input ready);
	modport sink (input valid, operation, start_day, start_month, start_year, day_count,
		output ready);
endinterface

// ===== rtl/cdo_out_if.sv =====
// Result channel of the calendar date offset block.
// Depends on cdo_pkg for field widths.
interface cdo_out_if import cdo_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [4:0]        result_day;
	logic [3:0]        result_month;
	logic [YEAR_W-1:0] result_year;
	logic [2:0]        weekday;
	logic              error;

	modport source (output valid, result_day, result_month, result_year, weekday, error,
		input ready);
	modport sink (input valid, result_day, result_month, result_year, weekday, error,
		output ready);
endinterface

// ===== rtl/cdo_ctrl.sv =====
// Sequencer for the date offset: walks init, check, month steps and
// weekday phases. Uses cdo_pkg command and status types.
module cdo_ctrl import cdo_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	input  logic out_ready,
	input  sts_t sts,
	output logic in_ready,
	output logic out_valid,
	output cmd_t cmd
);

	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_INITQ  = 4'd1;
	localparam logic [3:0] S_INITC  = 4'd2;
	localparam logic [3:0] S_CHECK  = 4'd3;
	localparam logic [3:0] S_STEP   = 4'd4;
	localparam logic [3:0] S_WSUM   = 4'd5;
	localparam logic [3:0] S_WMUL   = 4'd6;
	localparam logic [3:0] S_WFIN   = 4'd7;
	localparam logic [3:0] S_FINISH = 4'd8;

	logic [3:0] state_q, state_d;
	logic       out_valid_q;
	logic       out_load;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign out_load  = (state_q == S_FINISH) && (!out_valid_q || out_ready);

	always_comb begin
		state_d = state_q;
		cmd.op  = CMD_NONE;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.op  = CMD_LOAD;
					state_d = S_INITQ;
				end
			end
			S_INITQ: begin
				cmd.op  = CMD_INITQ;
				state_d = S_INITC;
			end
			S_INITC: begin
				cmd.op  = CMD_INITC;
				state_d = S_CHECK;
			end
			S_CHECK: begin
				if (!sts.date_ok) begin
					cmd.op  = CMD_ERR;
					state_d = S_FINISH;
				end else begin
					state_d = S_STEP;
				end
			end
			S_STEP: begin
				// a month step may carry the year past either end of the range
				if (sts.year_bad) begin
					cmd.op  = CMD_ERR;
					state_d = S_FINISH;
				end else if (sts.cnt_zero) begin
					state_d = S_WSUM;
				end else begin
					cmd.op = CMD_STEP;
				end
			end
			S_WSUM: begin
				cmd.op  = CMD_WSUM;
				state_d = S_WMUL;
			end
			S_WMUL: begin
				cmd.op  = CMD_WMUL;
				state_d = S_WFIN;
			end
			S_WFIN: begin
				cmd.op  = CMD_WFIN;
				state_d = S_FINISH;
			end
			S_FINISH: begin
				if (out_load) begin
					cmd.op  = CMD_OUT;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (out_load)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> state_q == S_INITQ)
		else $error("accepted request did not start init");

	a_finish_shows: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |=> out_valid_q && state_q == S_IDLE)
		else $error("finished result not presented");

	a_no_step_when_done: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.op == CMD_STEP |-> !sts.cnt_zero && !sts.year_bad)
		else $error("step issued with nothing left to do");

endmodule

// ===== rtl/cdo_dp.sv =====
// Datapath for the date offset: date registers, month stepper, year/100
// tracking, weekday arithmetic and result registers. Uses cdo_pkg.
module cdo_dp import cdo_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  cmd_t                cmd,
	input  logic                operation,
	input  logic [4:0]          start_day,
	input  logic [3:0]          start_month,
	input  logic [YEAR_W-1:0]   start_year,
	input  logic [COUNT_W-1:0]  day_count,
	output sts_t                sts,
	output logic [4:0]          result_day,
	output logic [3:0]          result_month,
	output logic [YEAR_W-1:0]   result_year,
	output logic [2:0]          weekday,
	output logic                error
);

	logic                  op_q;
	logic [4:0]            d_q;
	logic [3:0]            m_q;
	logic [YEAR_W-1:0]     y_q;
	logic [COUNT_BITS-1:0] cnt_q;
	logic [6:0]            q100_q;     // year / 100
	logic [6:0]            c100_q;     // year % 100
	logic [YEAR_W-1:0]     s_q;
	logic [11:0]           q7_q;
	logic [2:0]            wd_q;
	logic                  err_q;

	logic [4:0]        res_d_q;
	logic [3:0]        res_m_q;
	logic [YEAR_W-1:0] res_y_q;
	logic [2:0]        res_wd_q;
	logic              res_err_q;

	logic              leap;
	logic [4:0]        dim;
	logic [4:0]        rem;
	logic [26:0]       prod100;
	logic [YEAR_W-1:0] c100_full;
	logic [29:0]       prod7;
	logic              early;
	logic [YEAR_W-1:0] yy;
	logic [6:0]        qy;
	logic [YEAR_W:0]   wsum;
	logic [YEAR_W-1:0] wdiff;
	logic [3:0]        wrem;
	logic [4:0]        prev_dim;

	assign leap = ((y_q[1:0] == 2'd0) && (c100_q != 7'd0)) ||
		((c100_q == 7'd0) && (q100_q[1:0] == 2'd0));
	assign dim      = days_in(m_q, leap);
	assign rem      = dim - d_q;
	assign prev_dim = days_in(m_q - 4'd1, leap);

	assign prod100   = 27'(y_q) * 27'(RECIP100);
	assign c100_full = y_q - YEAR_W'(q100_q) * YEAR_W'(100);

	// Sakamoto: January and February count against the previous year
	assign early = (m_q < 4'd3);
	assign yy    = early ? y_q - YEAR_W'(1) : y_q;
	assign qy    = (early && c100_q == 7'd0) ? q100_q - 7'd1 : q100_q;
	assign wsum  = (YEAR_W+1)'(yy) + (YEAR_W+1)'(yy >> 2) - (YEAR_W+1)'(qy)
		+ (YEAR_W+1)'(qy >> 2) + (YEAR_W+1)'(wd_offset(m_q)) + (YEAR_W+1)'(d_q);
	assign prod7 = 30'(s_q) * 30'(RECIP7);
	assign wdiff = s_q - YEAR_W'(q7_q) * YEAR_W'(7);
	assign wrem  = wdiff[3:0];

	assign sts.year_bad = (y_q == '0) || (y_q > YEAR_W'(MAX_YEAR));
	assign sts.cnt_zero = (cnt_q == '0);
	assign sts.date_ok  = (m_q >= 4'd1) && (m_q <= 4'd12) && !sts.year_bad &&
		(d_q >= 5'd1) && (d_q <= dim);

	always_ff @(posedge clk) begin
		case (cmd.op)
			CMD_LOAD: begin
				op_q  <= operation;
				d_q   <= start_day;
				m_q   <= start_month;
				y_q   <= start_year;
				cnt_q <= day_count[COUNT_BITS-1:0];
			end
			CMD_INITQ: begin
				q100_q <= prod100[SHIFT100+6:SHIFT100];
			end
			CMD_INITC: begin
				c100_q <= c100_full[6:0];
			end
			CMD_STEP: begin
				if (!op_q) begin
					if (cnt_q > COUNT_BITS'(rem)) begin
						// jump to the first of the next month
						cnt_q <= cnt_q - COUNT_BITS'(rem) - COUNT_BITS'(1);
						d_q   <= 5'd1;
						if (m_q == 4'd12) begin
							m_q <= 4'd1;
							y_q <= y_q + YEAR_W'(1);
							if (c100_q == 7'd99) begin
								c100_q <= 7'd0;
								q100_q <= q100_q + 7'd1;
							end else begin
								c100_q <= c100_q + 7'd1;
							end
						end else begin
							m_q <= m_q + 4'd1;
						end
					end else begin
						d_q   <= d_q + cnt_q[4:0];
						cnt_q <= '0;
					end
				end else begin
					if (cnt_q >= COUNT_BITS'(d_q)) begin
						// jump to the last day of the previous month
						cnt_q <= cnt_q - COUNT_BITS'(d_q);
						if (m_q == 4'd1) begin
							m_q <= 4'd12;
							d_q <= 5'd31;
							y_q <= y_q - YEAR_W'(1);
							if (c100_q == 7'd0) begin
								c100_q <= 7'd99;
								q100_q <= q100_q - 7'd1;
							end else begin
								c100_q <= c100_q - 7'd1;
							end
						end else begin
							m_q <= m_q - 4'd1;
							d_q <= prev_dim;
						end
					end else begin
						d_q   <= d_q - cnt_q[4:0];
						cnt_q <= '0;
					end
				end
			end
			CMD_ERR: begin
				d_q   <= 5'd1;
				m_q   <= 4'd1;
				y_q   <= YEAR_W'(1);
				wd_q  <= 3'd1;
				err_q <= 1'b1;
			end
			CMD_WSUM: begin
				s_q <= wsum[YEAR_W-1:0];
			end
			CMD_WMUL: begin
				q7_q <= prod7[SHIFT7+11:SHIFT7];
			end
			CMD_WFIN: begin
				wd_q  <= (wrem >= 4'd7) ? 3'(wrem - 4'd7) : wrem[2:0];
				err_q <= 1'b0;
			end
			CMD_OUT: begin
				res_d_q   <= d_q;
				res_m_q   <= m_q;
				res_y_q   <= y_q;
				res_wd_q  <= wd_q;
				res_err_q <= err_q;
			end
			default: begin
			end
		endcase
	end

	assign result_day   = res_d_q;
	assign result_month = res_m_q;
	assign result_year  = res_y_q;
	assign weekday      = res_wd_q;
	assign error        = res_err_q;

	a_wd_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.op == CMD_WFIN |=> wd_q <= 3'd6)
		else $error("weekday out of range");

	a_err_date: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.op == CMD_ERR |=> err_q && d_q == 5'd1 && m_q == 4'd1 && y_q == YEAR_W'(1))
		else $error("error result is not 1 January of year 1");

	a_step_shrinks: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.op == CMD_STEP |=> cnt_q < $past(cnt_q))
		else $error("month step did not consume days");

endmodule

// ===== rtl/calendar_date_offset.sv =====
// Calendar date offset top level: moves a Gregorian date by a day count.
// Depends on cdo_pkg, cdo_in_if, cdo_out_if, cdo_ctrl and cdo_dp.
//
//   channel  | dir | payload
//   ---------+-----+------------------------------------------------------
//   in_ch    | in  | operation, start_day, start_month, start_year, day_count
//   out_ch   | out | result_day, result_month, result_year, weekday, error
//
// One request at a time. A valid request runs through init, the date check,
// the month stepper and the weekday phases; an invalid start date goes from
// the check straight to the result.
// Reset is asynchronous and clears only the sequencer and output valid.
// A result waiting on out_ch does not block the next request; a finished
// request waits in place until the output register frees.
module calendar_date_offset import cdo_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	cdo_in_if.sink   in_ch,
	cdo_out_if.source out_ch
);

	cmd_t cmd;
	sts_t sts;

	cdo_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_ch.valid),
		.out_ready (out_ch.ready),
		.sts       (sts),
		.in_ready  (in_ch.ready),
		.out_valid (out_ch.valid),
		.cmd       (cmd)
	);

	cdo_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.operation    (in_ch.operation),
		.start_day    (in_ch.start_day),
		.start_month  (in_ch.start_month),
		.start_year   (in_ch.start_year),
		.day_count    (in_ch.day_count),
		.sts          (sts),
		.result_day   (out_ch.result_day),
		.result_month (out_ch.result_month),
		.result_year  (out_ch.result_year),
		.weekday      (out_ch.weekday),
		.error        (out_ch.error)
	);

endmodule

// ===== tb/sv/tb_calendar_date_offset.sv =====
// Testbench for calendar_date_offset: bursts of directed and random requests,
// results checked in order against a serial-day-number predictor.
// Depends on cdo_pkg, cdo_in_if, cdo_out_if and the calendar_date_offset RTL.
module tb_calendar_date_offset;
	timeunit 1ns;
	timeprecision 1ps;
	import cdo_pkg::*;

	localparam logic OP_ADD = 1'b0;
	localparam logic OP_SUB = 1'b1;
	localparam int   RANDOM_REQS = 115;

	typedef struct packed {
		logic               op;
		logic [4:0]         day;
		logic [3:0]         month;
		logic [YEAR_W-1:0]  year;
		logic [COUNT_W-1:0] count;
		logic               drain;  // hold off until all results are back
	} date_req_t;

	typedef struct packed {
		logic [4:0]        day;
		logic [3:0]        month;
		logic [YEAR_W-1:0] year;
		logic [2:0]        wday;
		logic              err;
	} date_res_t;

	typedef struct {
		date_req_t req;
		date_res_t res;
	} offset_check_t;

	localparam int unsigned MONTH_LEN [13] = '{0, 31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
	localparam int unsigned SAKAMOTO [12]  = '{0, 3, 2, 5, 0, 3, 5, 1, 4, 6, 2, 4};

	logic clk;
	logic arst_n;

	cdo_in_if  req_if ();
	cdo_out_if res_if ();

	calendar_date_offset dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (req_if),
		.out_ch (res_if)
	);

	date_req_t     pending_reqs [$];
	offset_check_t date_expect [$];
	date_req_t     next_req;
	offset_check_t taken_chk;
	offset_check_t due_chk;
	date_res_t     got_res;
	int            reqs_sent;
	int            reqs_taken;
	int            burst_left;
	int            gap_left;
	int            fail_count;
	logic [15:0]   stall_pat;
	logic [3:0]    stall_pos;

	always #5 clk = ~clk;

	// ---------------- predictor ----------------

	function automatic bit is_leap_year(int unsigned y);
		return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
	endfunction

	function automatic int unsigned month_length(int unsigned m, int unsigned y);
		if (m < 1 || m > 12)
			return 0;
		if (m == 2 && is_leap_year(y))
			return 29;
		return MONTH_LEN[m];
	endfunction

	// days since 1 Jan of year 1
	function automatic longint day_number(int unsigned d, int unsigned m, int unsigned y);
		longint p;
		longint n;
		p = longint'(y) - 1;
		n = p * 365 + p / 4 - p / 100 + p / 400;
		for (int unsigned k = 1; k < m; k++)
			n += month_length(k, y);
		return n + d - 1;
	endfunction

	function automatic date_res_t date_of(longint n);
		date_res_t   r;
		longint      q400, rem, q100, q4, q1;
		int unsigned yr, mo;
		q400 = n / 146097;
		rem  = n % 146097;
		q100 = rem / 36524;
		if (q100 > 3)
			q100 = 3;
		rem -= q100 * 36524;
		q4   = rem / 1461;
		rem -= q4 * 1461;
		q1   = rem / 365;
		if (q1 > 3)
			q1 = 3;
		rem -= q1 * 365;
		yr = q400 * 400 + q100 * 100 + q4 * 4 + q1 + 1;
		mo = 1;
		while (mo < 12 && rem >= month_length(mo, yr)) begin
			rem -= month_length(mo, yr);
			mo++;
		end
		r.day   = rem + 1;
		r.month = mo;
		r.year  = yr;
		r.wday  = 0;
		r.err   = 1'b0;
		return r;
	endfunction

	function automatic logic [2:0] day_of_week(int unsigned d, int unsigned m, int unsigned y);
		int unsigned yy;
		yy = (m < 3) ? y - 1 : y;
		return (yy + yy / 4 - yy / 100 + yy / 400 + SAKAMOTO[(m - 1) % 12] + d) % 7;
	endfunction

	function automatic date_res_t predict_offset(date_req_t r);
		date_res_t res;
		longint    n;
		longint    last;
		longint    cnt;
		res.day   = 1;
		res.month = 1;
		res.year  = 1;
		res.err   = 1'b1;
		cnt = longint'(r.count) & ((longint'(1) << COUNT_BITS) - 1);
		if (r.month >= 1 && r.month <= 12 && r.year >= 1 && r.year <= MAX_YEAR &&
				r.day >= 1 && r.day <= month_length(r.month, r.year)) begin
			n    = day_number(r.day, r.month, r.year);
			last = day_number(31, 12, MAX_YEAR);
			n    = (r.op == OP_SUB) ? n - cnt : n + cnt;
			if (n >= 0 && n <= last) begin
				res     = date_of(n);
				res.err = 1'b0;
			end
		end
		res.wday = day_of_week(res.day, res.month, res.year);
		return res;
	endfunction

	// ---------------- stimulus ----------------

	task automatic queue_req(logic op, int unsigned d, int unsigned m, int unsigned y,
			int unsigned cnt, bit drain = 1'b0);
		date_req_t r;
		r.op    = op;
		r.day   = d;
		r.month = m;
		r.year  = y;
		r.count = cnt;
		r.drain = drain;
		pending_reqs.push_back(r);
	endtask

	task automatic queue_random_req(bit drain);
		int unsigned y, m, d, cnt, pick;
		pick = $urandom_range(99, 0);
		if (pick < 15) begin
			// noise: raw field values, mostly malformed dates
			queue_req($urandom_range(1, 0), $urandom_range(31, 0), $urandom_range(15, 0),
				$urandom_range(16383, 0), $urandom_range(65535, 0), drain);
			return;
		end
		pick = $urandom_range(9, 0);
		if (pick == 0)
			y = $urandom_range(3, 1);
		else if (pick == 1)
			y = $urandom_range(MAX_YEAR, MAX_YEAR - 2);
		else
			y = $urandom_range(MAX_YEAR, 1);
		m = $urandom_range(12, 1);
		d = $urandom_range(month_length(m, y), 1);
		pick = $urandom_range(19, 0);
		if (pick < 9)
			cnt = $urandom_range(40, 0);
		else if (pick < 15)
			cnt = $urandom_range(1000, 0);
		else if (pick < 18)
			cnt = $urandom_range(65535, 0);
		else
			cnt = $urandom_range(65535, 60000);
		queue_req($urandom_range(1, 0), d, m, y, cnt, drain);
	endtask

	task automatic note_mismatch(string msg);
		fail_count++;
		if (fail_count <= 10)
			$display("%s", msg);
	endtask

	initial begin
		clk          = 1'b0;
		arst_n       = 1'b0;
		req_if.valid = 1'b0;
		req_if.operation   = OP_ADD;
		req_if.start_day   = '0;
		req_if.start_month = '0;
		req_if.start_year  = '0;
		req_if.day_count   = '0;
		res_if.ready = 1'b0;
		reqs_sent    = 0;
		reqs_taken   = 0;
		burst_left   = 4;
		gap_left     = 0;
		fail_count   = 0;
		stall_pos    = '0;
		stall_pat    = '1;

		// directed: zero count, leap handling, rollover, range limits, bad dates
		queue_req(OP_ADD, 15, 6, 2024, 0);
		queue_req(OP_ADD, 29, 2, 2020, 1);
		queue_req(OP_ADD, 1, 1, 2020, 366);
		queue_req(OP_ADD, 28, 2, 2019, 1);
		queue_req(OP_ADD, 28, 2, 1900, 1);
		queue_req(OP_ADD, 28, 2, 2000, 1);
		queue_req(OP_ADD, 31, 12, 1999, 1);
		queue_req(OP_SUB, 1, 1, 2000, 1);
		queue_req(OP_SUB, 1, 3, 2000, 1);
		queue_req(OP_SUB, 1, 1, 1, 0);
		queue_req(OP_SUB, 1, 1, 1, 1);
		queue_req(OP_ADD, 1, 1, 1, 65535);
		queue_req(OP_ADD, 31, 12, MAX_YEAR, 0);
		queue_req(OP_ADD, 31, 12, MAX_YEAR, 1);
		queue_req(OP_SUB, 31, 12, MAX_YEAR, 65535);
		queue_req(OP_ADD, 0, 5, 2010, 3);
		queue_req(OP_ADD, 31, 4, 2010, 3);
		queue_req(OP_ADD, 29, 2, 2019, 3);
		queue_req(OP_SUB, 30, 2, 2020, 3);
		queue_req(OP_ADD, 10, 0, 2010, 3);
		queue_req(OP_ADD, 10, 13, 2010, 3);
		queue_req(OP_SUB, 31, 15, 2010, 3);
		queue_req(OP_ADD, 10, 10, 0, 3);
		queue_req(OP_ADD, 10, 10, MAX_YEAR + 1, 3);
		queue_req(OP_SUB, 31, 1, 16383, 65535);
		for (int i = 0; i < RANDOM_REQS; i++)
			queue_random_req(i == 0 || i == 60 || i == 110);

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (pending_reqs.size() != 0 || reqs_taken != reqs_sent || date_expect.size() != 0)
			@(posedge clk);
		repeat (64) @(posedge clk);
		if (fail_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

	initial begin
		#16ms;
		$display("status: fail");
		$finish;
	end

	// ---------------- request driver ----------------

	always @(negedge clk) begin
		if (!arst_n) begin
			req_if.valid <= 1'b0;
		end else if (!req_if.valid || reqs_taken == reqs_sent) begin
			if (gap_left > 0) begin
				req_if.valid <= 1'b0;
				gap_left <= gap_left - 1;
			end else if (pending_reqs.size() == 0 ||
					(pending_reqs[0].drain && date_expect.size() != 0)) begin
				req_if.valid <= 1'b0;
			end else begin
				next_req = pending_reqs.pop_front();
				req_if.operation   <= next_req.op;
				req_if.start_day   <= next_req.day;
				req_if.start_month <= next_req.month;
				req_if.start_year  <= next_req.year;
				req_if.day_count   <= next_req.count;
				req_if.valid       <= 1'b1;
				reqs_sent <= reqs_sent + 1;
				if (burst_left <= 1) begin
					burst_left <= $urandom_range(16, 1);
					if ($urandom_range(2, 0) == 0)
						gap_left <= 0;
					else
						gap_left <= ($urandom_range(5, 0) == 0) ? $urandom_range(24, 1)
							: $urandom_range(5, 1);
				end else begin
					burst_left <= burst_left - 1;
				end
			end
		end
	end

	// ---------------- result stall pattern ----------------

	always @(negedge clk) begin
		if (stall_pos == 0) begin
			case ($urandom_range(3, 0))
				0:       stall_pat = '1;
				1:       stall_pat = 16'($urandom);
				2:       stall_pat = 16'($urandom & $urandom);
				default: stall_pat = 16'h8000;
			endcase
		end
		res_if.ready <= arst_n && stall_pat[stall_pos];
		stall_pos <= stall_pos + 1'b1;
	end

	// ---------------- monitor / checker ----------------

	always @(posedge clk) begin
		if (arst_n) begin
			if (res_if.valid && res_if.ready) begin
				got_res.day   = res_if.result_day;
				got_res.month = res_if.result_month;
				got_res.year  = res_if.result_year;
				got_res.wday  = res_if.weekday;
				got_res.err   = res_if.error;
				if (date_expect.size() == 0) begin
					note_mismatch($sformatf("unexpected result: %0d-%0d-%0d wd %0d err %0d",
						got_res.year, got_res.month, got_res.day, got_res.wday, got_res.err));
				end else begin
					due_chk = date_expect.pop_front();
					if (got_res !== due_chk.res)
						note_mismatch($sformatf({"mismatch for op %0d %0d-%0d-%0d cnt %0d: ",
							"exp %0d-%0d-%0d wd %0d err %0d, got %0d-%0d-%0d wd %0d err %0d"},
							due_chk.req.op, due_chk.req.year, due_chk.req.month,
							due_chk.req.day, due_chk.req.count,
							due_chk.res.year, due_chk.res.month, due_chk.res.day,
							due_chk.res.wday, due_chk.res.err,
							got_res.year, got_res.month, got_res.day, got_res.wday,
							got_res.err));
				end
			end
			if (req_if.valid && req_if.ready) begin
				taken_chk.req.op    = req_if.operation;
				taken_chk.req.day   = req_if.start_day;
				taken_chk.req.month = req_if.start_month;
				taken_chk.req.year  = req_if.start_year;
				taken_chk.req.count = req_if.day_count;
				taken_chk.req.drain = 1'b0;
				taken_chk.res = predict_offset(taken_chk.req);
				date_expect.push_back(taken_chk);
				reqs_taken <= reqs_taken + 1;
			end
		end
	end

endmodule
